### sv/dtt_pkg.sv
package dtt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int HANDLE_BITS = 32;
	localparam int TIME_BITS   = 48;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
	localparam int SCAN_BITS   = $clog2(TABLE_DEPTH + 1);
	localparam int RES_BITS    = $clog2(MAX_RESULTS + 1);
	localparam int ENTRY_BITS  = HANDLE_BITS + TIME_BITS;

	localparam logic [1:0] REQ_REGISTER = 2'd0;
	localparam logic [1:0] REQ_CANCEL   = 2'd1;
	localparam logic [1:0] REQ_TICK     = 2'd2;

	localparam logic [2:0] KIND_REGISTERED = 3'd0;
	localparam logic [2:0] KIND_FULL       = 3'd1;
	localparam logic [2:0] KIND_CANCELLED  = 3'd2;
	localparam logic [2:0] KIND_NOT_FOUND  = 3'd3;
	localparam logic [2:0] KIND_EXPIRED    = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] timeout_ms;
		logic [31:0] cancel_handle;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] handle_out;
		logic        last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CSCAN,
		ST_CEVAL,
		ST_TSCAN,
		ST_TEVAL
	} state_t;

endpackage

### sv/deadline_timeout_table.sv
// Table of one-shot millisecond timeouts with earliest-deadline expiry.
// Command channel: a transaction is taken when start is high and busy is low;
// req carries the request type, timeout length and cancel handle.
// Result channel: each result sits on result for one cycle with result_valid
// high; there is no back pressure, so the receiver must take every strobe.
// Register: handled in the idle state, with the result in the next cycle; a free slot
//   comes from a priority encoder over the valid flops.
// Cancel: one pass over the entry RAM (one read per cycle, each word compared as it
//   arrives, then an evaluation state), one result.
// Tick: time advances, then repeated passes over the RAM pick the earliest
//   due entry each time; a found entry is held one pass so that the last
//   flag can be set on the final result.
// The handle/deadline RAM has a single read port, so each search is a pass over it.
// Reset clears valid bits, time (to zero) and the handle counter (to one);
// RAM contents need no clearing since only valid slots are used.
module deadline_timeout_table
	import dtt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic result_valid,
	output rsp_t result
);

	state_t state_q, state_d;

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TIME_BITS-1:0]   time_q;
	logic [HANDLE_BITS-1:0] next_h_q;

	logic [SCAN_BITS-1:0]   cnt_q;
	logic                   vld_s1;
	logic [IDX_BITS-1:0]    idx_s1;
	logic                   found_q;
	logic [IDX_BITS-1:0]    best_idx_q;
	logic [HANDLE_BITS-1:0] best_h_q;
	logic [TIME_BITS-1:0]   best_dl_q;
	logic [HANDLE_BITS-1:0] key_q;
	logic                   pend_q;
	logic [HANDLE_BITS-1:0] pend_h_q;
	logic [RES_BITS-1:0]    res_cnt_q;

	logic                   out_v_q;
	rsp_t                   out_q;

	// entry RAM: {handle, deadline}
	logic                   ram_we;
	logic [IDX_BITS-1:0]    ram_waddr;
	logic [ENTRY_BITS-1:0]  ram_wdata;
	logic [ENTRY_BITS-1:0]  ram_rdata;
	logic [HANDLE_BITS-1:0] rd_h;
	logic [TIME_BITS-1:0]   rd_dl;

	logic                   accept;
	logic                   any_free;
	logic [IDX_BITS-1:0]    free_idx;
	logic [HANDLE_BITS-1:0] next_h_inc;
	logic                   scan_end;
	logic                   hit_c;
	logic                   hit_t;
	logic                   have_t;

	dtt_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q[IDX_BITS-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_h  = ram_rdata[ENTRY_BITS-1:TIME_BITS];
	assign rd_dl = ram_rdata[TIME_BITS-1:0];

	assign accept = start && !busy;

	// lowest free slot
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = IDX_BITS'(i);
			end
		end
	end

	assign next_h_inc = next_h_q + 1'b1;

	assign ram_we    = accept && (req.req_type == REQ_REGISTER) && any_free;
	assign ram_waddr = free_idx;
	assign ram_wdata = {next_h_q, time_q + TIME_BITS'(req.timeout_ms)};

	assign scan_end = (cnt_q == SCAN_BITS'(TABLE_DEPTH));

	// compare stage, one RAM word per cycle
	assign hit_c = vld_s1 && valid_q[idx_s1] && (rd_h == key_q) && !found_q;
	assign hit_t = vld_s1 && valid_q[idx_s1] && (rd_dl <= time_q) &&
		(!found_q || (rd_dl < best_dl_q) || ((rd_dl == best_dl_q) && (rd_h < best_h_q)));
	assign have_t = found_q && (res_cnt_q != RES_BITS'(MAX_RESULTS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_CANCEL) begin
						state_d = ST_CSCAN;
					end else if (req.req_type == REQ_TICK) begin
						state_d = ST_TSCAN;
					end
				end
			end
			ST_CSCAN: begin
				if (scan_end) begin
					state_d = ST_CEVAL;
				end
			end
			ST_CEVAL: state_d = ST_IDLE;
			ST_TSCAN: begin
				if (scan_end) begin
					state_d = ST_TEVAL;
				end
			end
			ST_TEVAL: state_d = have_t ? ST_TSCAN : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy         = (state_q != ST_IDLE);
		result_valid = out_v_q;
		result       = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			time_q    <= '0;
			next_h_q  <= HANDLE_BITS'(1);
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			pend_q    <= 1'b0;
			res_cnt_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					vld_s1    <= 1'b0;
					found_q   <= 1'b0;
					pend_q    <= 1'b0;
					res_cnt_q <= '0;
					out_v_q   <= accept && (req.req_type == REQ_REGISTER);
					if (accept) begin
						case (req.req_type)
							REQ_REGISTER: begin
								if (any_free) begin
									valid_q[free_idx] <= 1'b1;
									next_h_q <= (next_h_inc == '0) ?
										HANDLE_BITS'(1) : next_h_inc;
								end
							end
							REQ_TICK: time_q <= time_q + 1'b1;
							default: ;
						endcase
					end
				end
				ST_CSCAN, ST_TSCAN: begin
					out_v_q <= 1'b0;
					vld_s1  <= !scan_end;
					idx_s1  <= cnt_q[IDX_BITS-1:0];
					if (!scan_end) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if ((state_q == ST_CSCAN) ? hit_c : hit_t) begin
						found_q    <= 1'b1;
						best_idx_q <= idx_s1;
						best_h_q   <= rd_h;
						best_dl_q  <= rd_dl;
					end
				end
				ST_CEVAL: begin
					out_v_q <= 1'b1;
					if (found_q) begin
						valid_q[best_idx_q] <= 1'b0;
					end
				end
				ST_TEVAL: begin
					cnt_q   <= '0;
					vld_s1  <= 1'b0;
					found_q <= 1'b0;
					out_v_q <= pend_q;
					if (have_t) begin
						valid_q[best_idx_q] <= 1'b0;
						pend_q    <= 1'b1;
						pend_h_q  <= best_h_q;
						res_cnt_q <= res_cnt_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
				end
				default: out_v_q <= 1'b0;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q <= req.cancel_handle;
				if (any_free) begin
					out_q <= '{kind: KIND_REGISTERED, handle_out: next_h_q, last: 1'b1};
				end else begin
					out_q <= '{kind: KIND_FULL, handle_out: '0, last: 1'b1};
				end
			end
			ST_CEVAL: begin
				if (found_q) begin
					out_q <= '{kind: KIND_CANCELLED, handle_out: best_h_q, last: 1'b1};
				end else begin
					out_q <= '{kind: KIND_NOT_FOUND, handle_out: key_q, last: 1'b1};
				end
			end
			ST_TEVAL: begin
				out_q <= '{kind: KIND_EXPIRED, handle_out: pend_h_q, last: !have_t};
			end
			default: ;
		endcase
	end

endmodule

### sv/dtt_ram.sv
module dtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### dv/tb_deadline_timeout_table.sv
// Testbench for the deadline timeout table.
// A scoreboard model of the slot table (valid/handle/deadline per slot, the
// millisecond clock and the handle counter) runs beside the block.
// Every accepted command transaction is applied to the model, which queues
// the results it predicts. Every result strobe is checked against the oldest
// queued prediction.
module tb_deadline_timeout_table;
	import dtt_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;    // ignored by the block
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         SETTLE_CYCLES = 400;  // longer than a full 16-expiry tick

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic result_valid;
	rsp_t result;

	deadline_timeout_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	always #4 clk = ~clk;

	// ---- timer table model ----
	logic        tbl_valid [TABLE_DEPTH];
	logic [31:0] tbl_handle [TABLE_DEPTH];
	logic [47:0] tbl_deadline [TABLE_DEPTH];
	logic [47:0] now_ms;
	logic [31:0] handle_ctr;
	rsp_t        pending_rsp [$];

	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_expired = 0;
	int n_full = 0;
	int cycles = 0;

	task automatic report(input string what, input rsp_t got, input rsp_t want);
		errors++;
		$display("MISMATCH %s: got kind=%0d handle=%h last=%0d, want kind=%0d handle=%h last=%0d",
			what, got.kind, got.handle_out, got.last, want.kind, want.handle_out,
			want.last);
	endtask

	function automatic rsp_t mk_rsp(logic [2:0] k, logic [31:0] h, logic l);
		rsp_t r;
		r.kind = k;
		r.handle_out = h;
		r.last = l;
		return r;
	endfunction

	task automatic table_reset();
		for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
		now_ms = '0;
		handle_ctr = 32'd1;
	endtask

	// Queue one predicted result.
	task automatic expect_rsp(input rsp_t x);
		pending_rsp = {pending_rsp, x};
	endtask

	// Apply one accepted transaction to the model and queue its results.
	task automatic apply_request(input req_t r);
		int slot;
		int best;
		int n;
		rsp_t burst [$];
		slot = -1;
		case (r.req_type)
			REQ_REGISTER: begin
				for (int i = TABLE_DEPTH - 1; i >= 0; i--)
					if (!tbl_valid[i]) slot = i;
				if (slot < 0) begin
					expect_rsp(mk_rsp(KIND_FULL, '0, 1'b1));
				end else begin
					tbl_valid[slot] = 1'b1;
					tbl_handle[slot] = handle_ctr;
					tbl_deadline[slot] = now_ms + {16'd0, r.timeout_ms};
					expect_rsp(mk_rsp(KIND_REGISTERED, handle_ctr, 1'b1));
					handle_ctr = handle_ctr + 1;
					if (handle_ctr == 0) handle_ctr = 32'd1;   // handle 0 is never issued
				end
			end
			REQ_CANCEL: begin
				// lowest slot wins if a wrapped counter ever duplicated a handle
				for (int i = TABLE_DEPTH - 1; i >= 0; i--)
					if (tbl_valid[i] && tbl_handle[i] == r.cancel_handle) slot = i;
				if (slot < 0) begin
					expect_rsp(mk_rsp(KIND_NOT_FOUND, r.cancel_handle, 1'b1));
				end else begin
					tbl_valid[slot] = 1'b0;
					expect_rsp(mk_rsp(KIND_CANCELLED, tbl_handle[slot], 1'b1));
				end
			end
			REQ_TICK: begin
				now_ms = now_ms + 1;
				n = 0;
				while (n < MAX_RESULTS) begin
					best = -1;
					for (int i = 0; i < TABLE_DEPTH; i++) begin
						if (!tbl_valid[i] || tbl_deadline[i] > now_ms) continue;
						// earliest deadline, then smaller handle, then lower slot
						if (best < 0 || tbl_deadline[i] < tbl_deadline[best] ||
						    (tbl_deadline[i] == tbl_deadline[best] &&
						     tbl_handle[i] < tbl_handle[best]))
							best = i;
					end
					if (best < 0) break;
					tbl_valid[best] = 1'b0;
					burst = {burst, mk_rsp(KIND_EXPIRED, tbl_handle[best], 1'b0)};
					n++;
				end
				if (n > 0) burst[n - 1].last = 1'b1;
				foreach (burst[j]) expect_rsp(burst[j]);
			end
			default: ;  // unused request code: no results, no state change
		endcase
	endtask

	// ---- result checker ----
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_valid) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected result", result, '0);
			end else begin
				if (result !== pending_rsp[0])
					report("result", result, pending_rsp[0]);
				if (pending_rsp[0].kind == KIND_EXPIRED) n_expired++;
				if (pending_rsp[0].kind == KIND_FULL) n_full++;
				void'(pending_rsp.pop_front());
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_rsp.size());
			$display("status: fail");
			$finish;
		end
	end

	// ---- stimulus ----
	int gap_pct = 0;

	// Drive one transaction, hold it until accepted, then maybe idle.
	task automatic send(input req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		apply_request(r);
		n_sent++;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Hold off the sender until every predicted result has been seen.
	task automatic drain();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	function automatic req_t mk_req(logic [1:0] t, logic [31:0] tmo, logic [31:0] h);
		req_t r;
		r.req_type = t;
		r.timeout_ms = tmo;
		r.cancel_handle = h;
		return r;
	endfunction

	// Directed table: request plus, where obvious, the single result it gives.
	typedef struct {
		req_t r;
		bit   typed;
		rsp_t want;
	} row_t;
	row_t rows [$];

	function automatic void add_row(req_t r, bit typed, rsp_t want);
		row_t x;
		x.r = r;
		x.typed = typed;
		x.want = want;
		rows = {rows, x};
	endfunction

	// Handle of a random live entry, or a random value if the table is empty.
	function automatic logic [31:0] live_handle();
		int idx [$];
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (tbl_valid[i]) idx = {idx, i};
		if (idx.size() == 0) return $urandom;
		return tbl_handle[idx[$urandom_range(idx.size() - 1)]];
	endfunction

	function automatic req_t random_req();
		int pick;
		logic [31:0] tmo;
		logic [31:0] h;
		pick = $urandom_range(99);
		if (pick < 40) begin
			case ($urandom_range(9))
				0:       tmo = $urandom;             // long, mostly never expires
				1, 2:    tmo = $urandom_range(13, 60);
				default: tmo = $urandom_range(0, 12);
			endcase
			return mk_req(REQ_REGISTER, tmo, $urandom);
		end
		if (pick < 60) begin
			case ($urandom_range(9))
				0:       h = $urandom;
				1:       h = handle_ctr;              // next handle, not issued yet
				default: h = live_handle();
			endcase
			return mk_req(REQ_CANCEL, $urandom, h);
		end
		if (pick < 96) return mk_req(REQ_TICK, $urandom, $urandom);
		return mk_req(REQ_UNUSED, $urandom, $urandom);
	endfunction

	initial begin
		table_reset();

		// After reset: first handle is 1, zero timeout expires on the next tick.
		add_row(mk_req(REQ_REGISTER, 32'd0, '0), 1, mk_rsp(KIND_REGISTERED, 32'd1, 1'b1));
		add_row(mk_req(REQ_TICK, '0, '0), 1, mk_rsp(KIND_EXPIRED, 32'd1, 1'b1));
		add_row(mk_req(REQ_CANCEL, '1, 32'd0), 1, mk_rsp(KIND_NOT_FOUND, 32'd0, 1'b1));
		add_row(mk_req(REQ_CANCEL, '0, '1), 1, mk_rsp(KIND_NOT_FOUND, '1, 1'b1));
		add_row(mk_req(REQ_UNUSED, '1, '1), 0, '0);
		add_row(mk_req(REQ_REGISTER, '1, '0), 1, mk_rsp(KIND_REGISTERED, 32'd2, 1'b1));
		// fill the rest of the table; repeated short timeouts make deadline ties
		for (int i = 3; i <= 17; i++)
			add_row(mk_req(REQ_REGISTER, 32'(i % 3), '1), 1,
				mk_rsp(KIND_REGISTERED, 32'(i), 1'b1));
		add_row(mk_req(REQ_REGISTER, 32'd5, '0), 1, mk_rsp(KIND_FULL, 32'd0, 1'b1));
		add_row(mk_req(REQ_CANCEL, '0, 32'd2), 1, mk_rsp(KIND_CANCELLED, 32'd2, 1'b1));
		add_row(mk_req(REQ_TICK, '0, '0), 0, '0);
		add_row(mk_req(REQ_TICK, '0, '0), 0, '0);
		add_row(mk_req(REQ_CANCEL, '0, 32'd5), 0, '0);
		add_row(mk_req(REQ_TICK, '0, '0), 0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send(rows[i].r);
			if (rows[i].typed && pending_rsp[$] !== rows[i].want)
				report("directed row", pending_rsp[$], rows[i].want);
		end
		drain();

		// cancel any entry still live after the directed part
		for (int i = 0; i < TABLE_DEPTH; i++)
			if (tbl_valid[i]) send(mk_req(REQ_CANCEL, '0, tbl_handle[i]));

		// three idle profiles: light sender gaps, heavy gaps, none
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 6 : (phase == 1) ? 60 : 0;
			for (int k = 0; k < 64; k++) begin
				send(random_req());
				if (k == 32) drain();
			end
		end
		start <= 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d transactions sent, %0d results checked (%0d expiries, %0d table-full)",
			n_sent, n_checked, n_expired, n_full);
		$display("three sender idle profiles, ties, full table and unknown-handle cancels covered");
		if (errors == 0 && pending_rsp.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### deadline_timeout_table.f
sv/dtt_pkg.sv
sv/dtt_ram.sv
sv/deadline_timeout_table.sv
dv/tb_deadline_timeout_table.sv
